FILE: hw/rtl/bmsi_pkg.sv
// Shared types and constants for the bank mapper with scanline interrupt.
// Used by every module.
`default_nettype none

package bmsi_pkg;

	// Number of entries in the queue between the decoder and the result unit
	localparam int unsigned QueueDepth = 2;

	// Configuration register indexes
	localparam int unsigned CfgIndexWidth = 1;
	localparam int unsigned CfgDataWidth  = 9;
	localparam logic [CfgIndexWidth-1:0] CfgFourScreen = 1'b0;
	localparam logic [CfgIndexWidth-1:0] CfgPrgBanks   = 1'b1;
	localparam logic [CfgDataWidth-1:0]  PrgBanksReset = 9'd32;

	// Register decode: address bits 15, 14, 13 and 0
	localparam logic [15:0] AddrDecodeMask = 16'hE001;
	localparam logic [15:0] RegBankSelect  = 16'h8000;
	localparam logic [15:0] RegBankData    = 16'h8001;
	localparam logic [15:0] RegMirroring   = 16'hA000;
	localparam logic [15:0] RegIrqLatch    = 16'hC000;
	localparam logic [15:0] RegIrqReload   = 16'hC001;
	localparam logic [15:0] RegIrqDisable  = 16'hE000;
	localparam logic [15:0] RegIrqEnable   = 16'hE001;

	// Bank register selectors (low three bits of bank select)
	localparam logic [2:0] SelChrPair0 = 3'd0;
	localparam logic [2:0] SelChrPair1 = 3'd1;
	localparam logic [2:0] SelChr2     = 3'd2;
	localparam logic [2:0] SelChr3     = 3'd3;
	localparam logic [2:0] SelChr4     = 3'd4;
	localparam logic [2:0] SelChr5     = 3'd5;
	localparam logic [2:0] SelPrg0     = 3'd6;
	localparam logic [2:0] SelPrg1     = 3'd7;

	// PRG windows
	localparam logic [15:0] PrgWindow8000 = 16'h8000;
	localparam logic [15:0] PrgWindowA000 = 16'hA000;
	localparam logic [15:0] PrgWindowC000 = 16'hC000;

	// Offset of the upper half of a 2 KiB CHR pair
	localparam logic [15:0] ChrPairStep = 16'h0400;

	// First scanline outside the visible picture
	localparam logic [8:0] FirstBlankLine = 9'd241;

	typedef enum logic [2:0] {
		KindNone   = 3'd0,
		KindPrg    = 3'd1,
		KindChr    = 3'd2,
		KindMirror = 3'd3,
		KindIrq    = 3'd4
	} kind_t;

	typedef enum logic {
		ModeWrite = 1'b0,
		ModeTick  = 1'b1
	} mode_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] address;
		logic [7:0]  data_byte;
		logic [8:0]  line_number;
		logic        render_on;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] window;
		logic [7:0]  bank;
		logic        horizontal;
		logic        last;
	} result_t;

	// Classified command handed from the decoder to the result unit
	typedef struct packed {
		kind_t       kind;
		logic [15:0] window;
		logic [7:0]  bank;
		logic        horizontal;
		logic        pair;
	} cmd_t;

	typedef struct packed {
		logic       four_screen;
		logic [8:0] prg_banks;
	} cfg_t;

	// Queue status seen by the decoder and the result unit
	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bmsi_stream_if.sv
// Valid/ready stream interface carrying one payload struct per beat.
// Payload type comes from bmsi_pkg at the point of instantiation.
`default_nettype none

interface bmsi_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bmsi_front.sv
// Front end: accepts writes and ticks, updates mapper and counter state,
// and pushes one classified command per item. Depends on bmsi_pkg.
`default_nettype none

module bmsi_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	bmsi_stream_if.sink         item,
	input  wire bmsi_pkg::cfg_t cfg,
	input  wire bmsi_pkg::qstat_t qstat,
	output bmsi_pkg::cmd_t      cmd,
	output logic                push
);

	logic [7:0] bank_select_q;
	logic [7:0] irq_count_q;
	logic [7:0] irq_reload_q;
	logic       irq_enable_q;

	logic [15:0] reg_sel;
	logic [2:0]  sel;
	logic [2:0]  chr_off;
	logic        tick_live;
	logic [7:0]  count_next;

	assign item.ready = !qstat.full;
	assign push       = item.valid && item.ready;

	assign reg_sel   = item.payload.address & bmsi_pkg::AddrDecodeMask;
	assign sel       = bank_select_q[2:0];
	assign chr_off   = 3'(sel - bmsi_pkg::SelChr2);
	assign tick_live = (item.payload.line_number < bmsi_pkg::FirstBlankLine)
		&& item.payload.render_on;
	assign count_next = (irq_count_q == 8'd0) ? irq_reload_q : 8'(irq_count_q - 8'd1);

	// classify the item
	always_comb begin
		cmd.kind       = bmsi_pkg::KindNone;
		cmd.window     = 16'h0000;
		cmd.bank       = 8'h00;
		cmd.horizontal = 1'b0;
		cmd.pair       = 1'b0;
		if (item.payload.mode == bmsi_pkg::ModeTick) begin
			if (tick_live && irq_enable_q && count_next == 8'd0) begin
				cmd.kind = bmsi_pkg::KindIrq;
			end
		end else begin
			case (reg_sel)
				bmsi_pkg::RegBankSelect: begin
					cmd.kind   = bmsi_pkg::KindPrg;
					cmd.window = item.payload.data_byte[6] ? bmsi_pkg::PrgWindow8000
						: bmsi_pkg::PrgWindowC000;
					cmd.bank   = 8'(cfg.prg_banks[7:0] - 8'd2);
				end
				bmsi_pkg::RegBankData: begin
					case (sel)
						bmsi_pkg::SelChrPair0, bmsi_pkg::SelChrPair1: begin
							cmd.kind   = bmsi_pkg::KindChr;
							cmd.window = {3'b000, bank_select_q[7], sel[0], 11'd0};
							cmd.bank   = {item.payload.data_byte[7:1], 1'b0};
							cmd.pair   = 1'b1;
						end
						bmsi_pkg::SelChr2, bmsi_pkg::SelChr3,
						bmsi_pkg::SelChr4, bmsi_pkg::SelChr5: begin
							cmd.kind   = bmsi_pkg::KindChr;
							cmd.window = {3'b000, ~bank_select_q[7], chr_off[1:0], 10'd0};
							cmd.bank   = item.payload.data_byte;
						end
						bmsi_pkg::SelPrg0: begin
							cmd.kind   = bmsi_pkg::KindPrg;
							cmd.window = bank_select_q[6] ? bmsi_pkg::PrgWindowC000
								: bmsi_pkg::PrgWindow8000;
							cmd.bank   = item.payload.data_byte;
						end
						default: begin
							cmd.kind   = bmsi_pkg::KindPrg;
							cmd.window = bmsi_pkg::PrgWindowA000;
							cmd.bank   = item.payload.data_byte;
						end
					endcase
				end
				bmsi_pkg::RegMirroring: begin
					if (!cfg.four_screen) begin
						cmd.kind       = bmsi_pkg::KindMirror;
						cmd.horizontal = item.payload.data_byte[0];
					end
				end
				default: begin
					cmd.kind = bmsi_pkg::KindNone;
				end
			endcase
		end
	end

	// update mapper and counter state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= 8'h00;
			irq_count_q   <= 8'h00;
			irq_reload_q  <= 8'h00;
			irq_enable_q  <= 1'b0;
		end else if (push) begin
			if (item.payload.mode == bmsi_pkg::ModeTick) begin
				if (tick_live) begin
					irq_count_q <= count_next;
				end
			end else begin
				case (reg_sel)
					bmsi_pkg::RegBankSelect: bank_select_q <= item.payload.data_byte;
					bmsi_pkg::RegIrqLatch:   irq_reload_q  <= item.payload.data_byte;
					bmsi_pkg::RegIrqReload:  irq_count_q   <= 8'h00;
					bmsi_pkg::RegIrqDisable: irq_enable_q  <= 1'b0;
					bmsi_pkg::RegIrqEnable:  irq_enable_q  <= 1'b1;
					default: begin
						irq_enable_q <= irq_enable_q;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bmsi_queue.sv
// Short command queue between the front end and the result unit.
// Depends on bmsi_pkg for the command type.
`default_nettype none

module bmsi_queue #(
	parameter int unsigned DEPTH = bmsi_pkg::QueueDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire bmsi_pkg::cmd_t   push_cmd,
	input  wire logic             pop,
	output bmsi_pkg::cmd_t        head,
	output bmsi_pkg::qstat_t      qstat,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	bmsi_pkg::cmd_t entries_q [DEPTH];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign head           = entries_q[rd_ptr_q];
	assign qstat.full     = (count_q == CntW'(DEPTH));
	assign qstat.nonempty = (count_q != '0);
	assign count          = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : IdxW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : IdxW'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= CntW'(count_q + 1'b1);
				2'b01:   count_q <= CntW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bmsi_back.sv
// Result unit: expands queued commands into result beats, two for a
// 2 KiB CHR pair, through an output register. Depends on bmsi_pkg.
`default_nettype none

module bmsi_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bmsi_pkg::cmd_t   head,
	input  wire bmsi_pkg::qstat_t qstat,
	output logic                  pop,
	bmsi_stream_if.source         result
);

	logic               out_valid_q;
	bmsi_pkg::result_t  out_q;
	logic               second_q;
	logic               load;
	logic               take;
	bmsi_pkg::result_t  next_res;

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	assign load = !out_valid_q || result.ready;
	assign take = load && qstat.nonempty;
	// drop the head once its final beat is loaded
	assign pop  = take && (!head.pair || second_q);

	always_comb begin
		next_res.kind       = head.kind;
		next_res.window     = head.window;
		next_res.bank       = head.bank;
		next_res.horizontal = head.horizontal;
		next_res.last       = 1'b1;
		if (head.pair) begin
			if (second_q) begin
				next_res.window = head.window | bmsi_pkg::ChrPairStep;
				next_res.bank   = head.bank | 8'h01;
			end else begin
				next_res.last = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= qstat.nonempty;
			if (take && head.pair) begin
				second_q <= !second_q;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bank_mapper_scanline_irq_top.sv
// Cartridge bank mapper with scanline interrupt counter: top level.
// Instantiates bmsi_front, bmsi_queue and bmsi_back; depends on bmsi_pkg
// and bmsi_stream_if.
//
// Each beat on item is either a CPU register write (mode 0) or a scanline
// tick (mode 1). The front end decodes the write by address AND 0xE001,
// updates bank select, the interrupt latch, counter and enable at once,
// and pushes one classified command into a short queue. The result unit
// turns each command into result beats: one beat for most items, two for
// a write to a 2 KiB CHR pair (bank, then bank + 1 at window + 0x400, the
// second carrying last). A tick on a visible line (below 241) with
// rendering on reloads the counter from the latch when it is zero and
// decrements it otherwise; it reports an interrupt request when the
// counter is enabled and lands on zero. Items are taken every cycle while
// the queue has room; the result register delivers one beat per cycle
// while the receiver is ready, so single-result items sustain one item
// per cycle and CHR pair writes take two beats each. four_screen and
// prg_banks are written on the cfg port (index 0 and 1) and must only
// change while no item is in flight.
`default_nettype none

module bank_mapper_scanline_irq_top #(
	parameter int unsigned QUEUE_DEPTH = bmsi_pkg::QueueDepth
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	bmsi_stream_if.sink                             item,
	bmsi_stream_if.source                           result,
	input  wire logic                               cfg_we,
	input  wire logic [bmsi_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wire logic [bmsi_pkg::CfgDataWidth-1:0]  cfg_data
);

	bmsi_pkg::cfg_t   cfg_q;
	bmsi_pkg::cmd_t   push_cmd;
	bmsi_pkg::cmd_t   head;
	bmsi_pkg::qstat_t qstat;
	logic             push;
	logic             pop;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	// Configuration registers: plain indexed write, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_screen <= 1'b0;
			cfg_q.prg_banks   <= bmsi_pkg::PrgBanksReset;
		end else if (cfg_we) begin
			case (cfg_index)
				bmsi_pkg::CfgFourScreen: cfg_q.four_screen <= cfg_data[0];
				bmsi_pkg::CfgPrgBanks:   cfg_q.prg_banks   <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Front end: decode, update state, classify
	bmsi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.cmd    (push_cmd),
		.push   (push)
	);

	// Decoupling queue
	bmsi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat),
		.count    (q_count)
	);

	// Back end: expand commands into result beats
	bmsi_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

`ifndef ASSERT_OFF
	// only the first half of a CHR pair goes out without last
	a_nonlast_is_chr: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.payload.last) |-> (result.payload.kind == bmsi_pkg::KindChr))
		else $error("non-final result beat is not a CHR map");

	// the second half of a pair follows right after the first is taken
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !result.payload.last)
		|=> (result.valid && result.payload.last))
		else $error("second half of CHR pair did not follow");

	// queue occupancy stays within its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
		else $error("command queue overflow");

	// never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.nonempty)
		else $error("command queue underflow");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_bank_mapper_scanline_irq_top.sv
// Self-checking testbench for bank_mapper_scanline_irq_top: drives CPU writes
// and scanline ticks, predicts every result beat and checks them in order.
// Depends on bmsi_pkg, bmsi_stream_if and the mapper RTL; needs nothing else.
`default_nettype none

module tb_bank_mapper_scanline_irq_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmsi_pkg::*;

	// Cycles with no beat on either side before the run is declared hung.
	// The longest legal quiet stretch is the receiver hold-off.
	localparam int StallLimit  = 2000;
	// Margin waited after the last owed beat is back.
	localparam int DrainCycles = 4;
	// Upper CHR half, also the XOR applied by CHR inversion
	localparam logic [15:0] ChrHalf     = 16'h1000;
	// Offset of the second 2 KiB CHR pair
	localparam logic [15:0] ChrPairSpan = 16'h0800;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [CfgDataWidth-1:0]  cfg_data;

	bmsi_stream_if #(.payload_t(item_t))   item_if ();
	bmsi_stream_if #(.payload_t(result_t)) result_if ();

	bank_mapper_scanline_irq_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Mirror of the mapper state, kept in step with accepted beats
	logic [7:0] scan_count;
	logic [7:0] scan_latch;
	logic       scan_irq_on;
	logic [7:0] bank_sel;
	logic       four_screen_cfg;
	logic [8:0] prg_banks_cfg;

	// Result beats still owed by the block, oldest first
	result_t pending_remaps[$];

	int error_count;
	int idle_cycles;
	int hold_off;       // receiver hold-off, counted down by the sink process
	bit send_idling;    // sender inserts random gaps
	bit take_idling;    // receiver inserts random stalls

	function automatic void owe_beat(kind_t k, logic [15:0] win, logic [7:0] bank,
			logic horiz, logic fin);
		result_t r;
		r.kind       = k;
		r.window     = win;
		r.bank       = bank;
		r.horizontal = horiz;
		r.last       = fin;
		pending_remaps.push_back(r);
	endfunction

	// Advance the mirrored state by one accepted item and queue the beats it owes.
	function automatic void map_item(item_t it);
		logic [15:0] chr_base;
		logic [15:0] pair_win;
		logic [7:0]  pair_bank;
		logic [2:0]  sel;
		bit          silent;
		chr_base = bank_sel[7] ? ChrHalf : 16'h0000;
		sel      = bank_sel[2:0];
		silent   = 1'b0;
		if (it.mode == ModeTick) begin
			// Only visible lines with rendering on clock the counter
			if (it.line_number < FirstBlankLine && it.render_on) begin
				scan_count = (scan_count == 8'd0) ? scan_latch : scan_count - 8'd1;
				if (scan_irq_on && scan_count == 8'd0) begin
					owe_beat(KindIrq, '0, '0, 1'b0, 1'b1);
					return;
				end
			end
			owe_beat(KindNone, '0, '0, 1'b0, 1'b1);
			return;
		end
		case (it.address & AddrDecodeMask)
		RegBankSelect: begin
			bank_sel = it.data_byte;
			owe_beat(KindPrg, it.data_byte[6] ? PrgWindow8000 : PrgWindowC000,
				8'(prg_banks_cfg - 9'd2), 1'b0, 1'b1);
		end
		RegBankData: begin
			case (sel)
			SelChrPair0, SelChrPair1: begin
				pair_win  = (sel == SelChrPair1) ? ChrPairSpan : 16'h0000;
				pair_bank = it.data_byte & 8'hFE;
				owe_beat(KindChr, chr_base ^ pair_win, pair_bank, 1'b0, 1'b0);
				owe_beat(KindChr, chr_base ^ (pair_win + ChrPairStep),
					pair_bank + 8'd1, 1'b0, 1'b1);
			end
			SelPrg0: begin
				owe_beat(KindPrg, bank_sel[6] ? PrgWindowC000 : PrgWindow8000,
					it.data_byte, 1'b0, 1'b1);
			end
			SelPrg1: begin
				owe_beat(KindPrg, PrgWindowA000, it.data_byte, 1'b0, 1'b1);
			end
			default: begin
				owe_beat(KindChr,
					chr_base ^ (ChrHalf + ChrPairStep * 16'(sel - SelChr2)),
					it.data_byte, 1'b0, 1'b1);
			end
			endcase
		end
		RegMirroring: begin
			if (!four_screen_cfg)
				owe_beat(KindMirror, '0, '0, it.data_byte[0], 1'b1);
			else
				silent = 1'b1;
		end
		RegIrqLatch: begin
			scan_latch = it.data_byte;
			silent     = 1'b1;
		end
		RegIrqReload: begin
			scan_count = 8'd0;
			silent     = 1'b1;
		end
		RegIrqDisable: begin
			scan_irq_on = 1'b0;
			silent      = 1'b1;
		end
		RegIrqEnable: begin
			scan_irq_on = 1'b1;
			silent      = 1'b1;
		end
		default: silent = 1'b1;
		endcase
		if (silent)
			owe_beat(KindNone, '0, '0, 1'b0, 1'b1);
	endfunction

	// Random address that decodes to the given register
	function automatic logic [15:0] reg_addr(logic [15:0] code);
		return (16'($urandom) & ~AddrDecodeMask) | code;
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.mode        = $urandom_range(0, 1) ? ModeTick : ModeWrite;
		it.data_byte   = 8'($urandom);
		it.line_number = 9'($urandom_range(0, 261));
		it.render_on   = 1'($urandom);
		case ($urandom_range(0, 9))
		0:       it.address = reg_addr(RegBankSelect);
		1, 2:    it.address = reg_addr(RegBankData);
		3:       it.address = reg_addr(RegMirroring);
		4:       it.address = reg_addr(RegIrqLatch);
		5:       it.address = reg_addr(RegIrqReload);
		6:       it.address = reg_addr(RegIrqDisable);
		7:       it.address = reg_addr(RegIrqEnable);
		8:       it.address = 16'($urandom);
		default: it.address = 16'($urandom_range(0, 16'h7FFF));
		endcase
		return it;
	endfunction

	// Offer one beat; hold it until the block takes it, then predict.
	task automatic send_item(input item_t it);
		if (send_idling && $urandom_range(0, 3) == 0) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_if.valid   <= 1'b1;
		item_if.payload <= it;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		map_item(it);
	endtask

	// CPU write; the tick-only fields get random filler.
	task automatic cpu_write(input logic [15:0] addr, input logic [7:0] data);
		item_t it;
		it.mode        = ModeWrite;
		it.address     = addr;
		it.data_byte   = data;
		it.line_number = 9'($urandom);
		it.render_on   = 1'($urandom);
		send_item(it);
	endtask

	// Scanline tick; the write-only fields get random filler.
	task automatic tick(input logic [8:0] line, input logic render);
		item_t it;
		it.mode        = ModeTick;
		it.address     = 16'($urandom);
		it.data_byte   = 8'($urandom);
		it.line_number = line;
		it.render_on   = render;
		send_item(it);
	endtask

	// Drop valid and wait until every owed beat is back, plus the pipe latency.
	task automatic settle();
		item_if.valid <= 1'b0;
		while (pending_remaps.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write both registers back to back; call only with the block idle.
	task automatic set_config(input logic fs, input logic [8:0] pb);
		cfg_we    <= 1'b1;
		cfg_index <= CfgFourScreen;
		cfg_data  <= CfgDataWidth'(fs);
		@(posedge clk);
		cfg_index <= CfgPrgBanks;
		cfg_data  <= pb;
		@(posedge clk);
		cfg_we          <= 1'b0;
		four_screen_cfg = fs;
		prg_banks_cfg   = pb;
	endtask

	// Hand-picked items at reset configuration: selectors 0, 1, 2, 5, 6, 7,
	// inversion, mirroring, dead writes and the counter corner cases.
	task automatic test_directed();
		cpu_write(16'h8000, 8'h00);  // PRG swap low: window C000
		cpu_write(16'h8001, 8'hFF);  // first CHR pair, bit 0 dropped
		cpu_write(16'h9FFE, 8'h81);  // aliased select: inversion on, second pair
		cpu_write(16'h8001, 8'h00);
		cpu_write(16'h8000, 8'h42);  // single CHR selector, PRG swap high
		cpu_write(16'h8001, 8'hAB);
		cpu_write(16'h8000, 8'hC5);  // last single CHR selector with inversion
		cpu_write(16'h9FFF, 8'h7F);  // aliased data write
		cpu_write(16'h8000, 8'h46);  // first PRG selector with swap
		cpu_write(16'h8001, 8'h01);
		cpu_write(16'h8000, 8'h07);  // second PRG selector
		cpu_write(16'h8001, 8'h80);
		cpu_write(16'hA000, 8'h01);  // horizontal mirroring
		cpu_write(16'hBFFE, 8'hFE);  // vertical mirroring via alias
		cpu_write(16'hA001, 8'h55);  // nothing visible
		cpu_write(16'h0000, 8'hFF);  // below the register space
		cpu_write(16'h7FFF, 8'h00);
		cpu_write(16'hC000, 8'h00);  // latch of zero
		cpu_write(16'hC001, 8'hFF);  // clear the count
		cpu_write(16'hE001, 8'h00);  // enable
		tick(9'd0, 1'b1);            // reload to zero: interrupt
		tick(9'd240, 1'b0);          // rendering off: no change
		tick(9'd241, 1'b1);          // first blank line: no change
		tick(9'd261, 1'b1);          // pre-render line: no change
		cpu_write(16'hE000, 8'hFF);  // disable
		tick(9'd240, 1'b1);          // count hits zero but disabled
	endtask

	// Walk several register settings, extremes included, with random traffic.
	task automatic test_config_sweep();
		logic       fs_list [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
		logic [8:0] pb_list [5] = '{9'd256, 9'd4, 9'd1, 9'd0, 9'd97};
		for (int s = 0; s < 5; s++) begin
			settle();
			set_config(fs_list[s], pb_list[s]);
			cpu_write(reg_addr(RegMirroring), 8'($urandom));
			cpu_write(reg_addr(RegBankSelect), 8'($urandom));
			repeat (90) send_item(random_item());
		end
	endtask

	// Well-formed counter setups followed by runs of ticks, with some noise.
	task automatic test_irq_sequences();
		logic [7:0] latch;
		for (int n = 0; n < 32; n++) begin
			send_idling = $urandom_range(0, 2) != 0;
			take_idling = $urandom_range(0, 2) != 0;
			case ($urandom_range(0, 5))
			0:       latch = 8'd0;
			1:       latch = 8'($urandom);
			default: latch = 8'($urandom_range(1, 6));
			endcase
			cpu_write(reg_addr(RegIrqLatch), latch);
			cpu_write(reg_addr(RegIrqReload), 8'($urandom));
			cpu_write(reg_addr($urandom_range(0, 4) ? RegIrqEnable : RegIrqDisable),
				8'($urandom));
			repeat ($urandom_range(3, 15)) begin
				case ($urandom_range(0, 11))
				0:       send_item(random_item());
				1:       tick(9'($urandom_range(241, 261)), 1'($urandom));
				2:       tick(9'($urandom_range(0, 240)), 1'b0);
				default: tick(9'($urandom_range(0, 240)), 1'b1);
				endcase
			end
		end
		send_idling = 1'b1;
		take_idling = 1'b1;
	endtask

	// Bank select then bank data, random content, occasional stray items.
	task automatic test_bank_sequences();
		for (int n = 0; n < 150; n++) begin
			cpu_write(reg_addr(RegBankSelect), 8'($urandom));
			if ($urandom_range(0, 5) == 0)
				send_item(random_item());
			cpu_write(reg_addr(RegBankData), 8'($urandom));
		end
	endtask

	// Hold the receiver off while the sender keeps offering CHR pair writes,
	// so the queue fills and item ready must drop.
	task automatic test_backpressure();
		settle();
		hold_off = 120;
		for (int n = 0; n < 15; n++) begin
			cpu_write(reg_addr(RegBankSelect), {$urandom_range(0, 1) ? 1'b1 : 1'b0,
				6'($urandom) & 6'h20, 1'($urandom)} & 8'hC1);
			cpu_write(reg_addr(RegBankData), 8'($urandom));
		end
		settle();
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		send_idling = 1'b0;
		take_idling = 1'b0;
		repeat (450) send_item(random_item());
	endtask

	// Receiver: long hold-off when asked, else random stall bursts.
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				result_if.ready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				result_if.ready <= 1'b0;
			end else if (take_idling && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(0, 4);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// Check each result beat against the oldest owed one; also run the watchdog.
	// Values read right after the edge are those the flops saw at that edge.
	always @(posedge clk) begin
		result_t want;
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("tb_bank_mapper_scanline_irq_top: errors");
			$finish;
		end else if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_remaps.size() == 0) begin
				$error("unexpected result beat: kind %0d window %h bank %0d",
					result_if.payload.kind, result_if.payload.window,
					result_if.payload.bank);
				error_count++;
			end else begin
				want = pending_remaps.pop_front();
				if (result_if.payload.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind,
						result_if.payload.kind);
					error_count++;
				end
				if (result_if.payload.window !== want.window) begin
					$error("window: expected %h, got %h", want.window,
						result_if.payload.window);
					error_count++;
				end
				if (result_if.payload.bank !== want.bank) begin
					$error("bank: expected %0d, got %0d", want.bank,
						result_if.payload.bank);
					error_count++;
				end
				if (result_if.payload.horizontal !== want.horizontal) begin
					$error("horizontal: expected %0d, got %0d", want.horizontal,
						result_if.payload.horizontal);
					error_count++;
				end
				if (result_if.payload.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last,
						result_if.payload.last);
					error_count++;
				end
			end
		end
	end

	initial begin
		// Known values on every input from time zero
		arst_n            = 1'b0;
		item_if.valid     = 1'b0;
		item_if.payload   = '0;
		result_if.ready   = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		scan_count        = 8'd0;
		scan_latch        = 8'd0;
		scan_irq_on       = 1'b0;
		bank_sel          = 8'd0;
		four_screen_cfg   = 1'b0;
		prg_banks_cfg     = PrgBanksReset;
		error_count       = 0;
		idle_cycles       = 0;
		hold_off          = 0;
		send_idling       = 1'b1;
		take_idling       = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_sweep();
		test_irq_sequences();
		test_bank_sequences();
		test_backpressure();
		test_full_rate();
		settle();

		if (error_count == 0)
			$display("tb_bank_mapper_scanline_irq_top: clean");
		else
			$display("tb_bank_mapper_scanline_irq_top: errors");
		$finish;
	end
endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/bmsi_pkg.sv
hw/rtl/bmsi_stream_if.sv
hw/rtl/bmsi_front.sv
hw/rtl/bmsi_queue.sv
hw/rtl/bmsi_back.sv
hw/rtl/bank_mapper_scanline_irq_top.sv
bench/tb_bank_mapper_scanline_irq_top.sv
